// ===== design/cps_pkg.sv =====
// Shared types, constants and the row line table of the charlieplexed PWM scanner.
// No dependencies. Every other file of the block but cps_checker uses this package.
package cps_pkg;

  localparam int unsigned ROWS    = 5;
  localparam int unsigned COLS    = 4;
  localparam int unsigned LEDS    = 20;
  localparam int unsigned LINES   = 5;
  localparam int unsigned LEVEL_W = 6;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned ROW_W   = 3;
  localparam int unsigned LANE_W  = 2;

  localparam logic [ROW_W-1:0]   ROW_FIRST = 3'd0;
  localparam logic [ROW_W-1:0]   ROW_LAST  = 3'd4;
  localparam logic [COLS-1:0]    COL_ALL   = 4'hF;
  localparam logic [IDX_W-1:0]   LED_LIMIT = 5'd20;

  // What one input transaction carries
  typedef enum logic {
    MODE_TICK  = 1'b0,
    MODE_WRITE = 1'b1
  } cps_mode_e;

  // One row of four brightness levels, lane 0 in the lowest bits
  typedef logic [COLS-1:0][LEVEL_W-1:0] cps_row_levels_t;

  // Row information that travels with a tick
  typedef struct packed {
    logic             wrap;
    logic [ROW_W-1:0] row;
  } cps_tick_t;

  // One brightness write into the level store
  typedef struct packed {
    logic               en;
    logic [ROW_W-1:0]   row;
    logic [LANE_W-1:0]  lane;
    logic [LEVEL_W-1:0] level;
  } cps_wr_t;

  // Line that serves as the common line of each row
  function automatic logic [LINES-1:0] row_line_bit(input logic [ROW_W-1:0] row);
    logic [LINES-1:0] bit_o;
    case (row)
      3'd0:    bit_o = 5'h01;
      3'd1:    bit_o = 5'h02;
      3'd2:    bit_o = 5'h04;
      3'd3:    bit_o = 5'h10;
      3'd4:    bit_o = 5'h08;
      default: bit_o = 5'h00;
    endcase
    return bit_o;
  endfunction

endpackage

// ===== design/cps_level_mem.sv =====
// Brightness store: five rows of four levels, one lane written per transaction,
// one whole row read into a register. Depends on cps_pkg.
module cps_level_mem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cps_pkg::cps_wr_t          wr_i,
  input  logic                      rd_en_i,
  input  logic [cps_pkg::ROW_W-1:0] rd_row_i,
  output cps_pkg::cps_row_levels_t  rd_levels_o
);

  cps_pkg::cps_row_levels_t mem_q [cps_pkg::ROWS];
  logic [cps_pkg::ROWS-1:0][cps_pkg::COLS-1:0] vld_q;
  cps_pkg::cps_row_levels_t rd_data_q;
  logic [cps_pkg::COLS-1:0] rd_vld_q;

  // Write one lane of a row; read a whole row
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.row][wr_i.lane] <= wr_i.level;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_row_i];
    end
  end

  // Mark lanes written since reset; capture their marks with the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= '0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.row][wr_i.lane] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_row_i];
      end
    end
  end

  // Lanes never written read as level zero
  always_comb begin
    for (int c = 0; c < cps_pkg::COLS; c++) begin
      rd_levels_o[c] = rd_vld_q[c] ? rd_data_q[c] : '0;
    end
  end

endmodule

// ===== design/cps_column_stage.sv =====
// Column stage: latches the row levels, switches columns off against the ramp,
// maps columns to lines and holds the result register. Depends on cps_pkg.
module cps_column_stage #(
  parameter int unsigned RAMP_W = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_valid_i,
  output logic                          tick_ready_o,
  input  cps_pkg::cps_tick_t            tick_i,
  input  logic [RAMP_W-1:0]             ramp_i,
  input  cps_pkg::cps_row_levels_t      rd_levels_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cps_pkg::LINES-1:0]     pin_direction_o,
  output logic [cps_pkg::LINES-1:0]     pin_level_o
);

  localparam int unsigned CMP_W = (RAMP_W > cps_pkg::LEVEL_W) ? RAMP_W : cps_pkg::LEVEL_W;

  logic                       b_valid_q;
  cps_pkg::cps_tick_t         b_tick_q;
  logic [RAMP_W-1:0]          b_ramp_q;
  logic                       b_adv;

  logic [cps_pkg::COLS-1:0]   col_en_q, col_en_d;
  cps_pkg::cps_row_levels_t   row_levels_q, levels_now;
  logic [cps_pkg::COLS-1:0]   match;

  logic [cps_pkg::LINES-1:0]  below, en_lines, lines, cols, row_bit, drive;
  logic                       out_valid_q;
  logic [cps_pkg::LINES-1:0]  out_dir_q, out_lvl_q;

  // Move the held tick on when the result register is free or being emptied
  assign b_adv        = b_valid_q && (!out_valid_q || out_ready_i);
  assign tick_ready_o = !b_valid_q || b_adv;

  // Switch off each column whose level the ramp meets
  always_comb begin
    levels_now = b_tick_q.wrap ? rd_levels_i : row_levels_q;
    for (int c = 0; c < cps_pkg::COLS; c++) begin
      match[c] = (CMP_W'(b_ramp_q) == CMP_W'(levels_now[c]));
    end
    col_en_d = (b_tick_q.wrap ? cps_pkg::COL_ALL : col_en_q) & ~match;
  end

  // Skip the row line, then swap lines three and four
  always_comb begin
    below    = (cps_pkg::LINES'(1) << b_tick_q.row) - cps_pkg::LINES'(1);
    en_lines = cps_pkg::LINES'(col_en_d);
    lines    = (en_lines & below) | ((en_lines & ~below) << 1);
    cols     = {lines[3], lines[4], lines[2:0]};
    row_bit  = cps_pkg::row_line_bit(b_tick_q.row);
    drive    = (cols != '0) ? (cols | row_bit) : '0;
  end

  // Hold the tick between memory read and column update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (tick_ready_o) begin
      b_valid_q <= tick_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_valid_i && tick_ready_o) begin
      b_tick_q <= tick_i;
      b_ramp_q <= ramp_i;
    end
  end

  // Update column mask and latched row levels as each tick retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_en_q     <= '0;
      row_levels_q <= '0;
    end else if (b_adv) begin
      col_en_q <= col_en_d;
      if (b_tick_q.wrap) begin
        row_levels_q <= rd_levels_i;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      out_dir_q <= drive;
      out_lvl_q <= (drive != '0) ? row_bit : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pin_direction_o = out_dir_q;
  assign pin_level_o     = out_lvl_q;

endmodule

// ===== design/charlieplex_pwm_scanner.sv =====
// Top level of the charlieplexed PWM scanner: ramp and row counters, brightness
// store and column stage. Depends on cps_pkg, cps_level_mem and cps_column_stage.
//
//   channel  dir  tdata (low bit up)                   tuser
//   s_axis   in   led_index[4:0] level[10:5] pad[15:11] mode
//   m_axis   out  pin_direction[4:0] pin_level[9:5]     -
//                 pad[15:10]
//
// One transaction a cycle, writes and ticks alike, while s_axis_tready is high. A
// tick loads the store's row read and the column stage together on acceptance, then
// enters the result register, which drives m_axis, when that is free or emptied.
// Reset presets counters and clears column mask, latched levels and the per-lane
// written marks of the store at once; there is no clearing pass.
// s_axis_tready falls only when the column stage and the result register are
// both full and m_axis_tready is low.
module charlieplex_pwm_scanner #(
  parameter int unsigned LEVELS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // led_index[4:0], level[10:5], zero pad
  input  logic        s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // pin_direction[4:0], pin_level[9:5], zero pad
);

  localparam int unsigned RAMP_W = $clog2(LEVELS);
  localparam logic [RAMP_W-1:0] RAMP_TOP = RAMP_W'(LEVELS - 1);

  logic [cps_pkg::IDX_W-1:0]   led_index;
  logic [cps_pkg::LEVEL_W-1:0] level;
  cps_pkg::cps_mode_e          mode;
  logic                        accept, tick_acc, wrap;

  logic [RAMP_W-1:0]           ramp_q, ramp_d;
  logic [cps_pkg::ROW_W-1:0]   row_q, row_d;

  cps_pkg::cps_wr_t            wr;
  cps_pkg::cps_tick_t          tick;
  cps_pkg::cps_row_levels_t    rd_levels;
  logic [cps_pkg::LINES-1:0]   pin_direction, pin_level;

  // Unpack the input transaction
  assign led_index = s_axis_tdata[4:0];
  assign level     = s_axis_tdata[10:5];
  assign mode      = cps_pkg::cps_mode_e'(s_axis_tuser);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign tick_acc  = accept && (mode == cps_pkg::MODE_TICK);

  // Store writes; indexes past the last LED are dropped
  always_comb begin
    wr.en    = accept && (mode == cps_pkg::MODE_WRITE) && (led_index < cps_pkg::LED_LIMIT);
    wr.row   = cps_pkg::ROW_W'(led_index >> cps_pkg::LANE_W);
    wr.lane  = led_index[cps_pkg::LANE_W-1:0];
    wr.level = level;
  end

  // Advance the ramp, and the row on each wrap
  always_comb begin
    wrap   = (ramp_q == RAMP_TOP);
    ramp_d = wrap ? '0 : ramp_q + RAMP_W'(1);
    if (wrap) begin
      row_d = (row_q == cps_pkg::ROW_LAST) ? cps_pkg::ROW_FIRST
                                           : row_q + cps_pkg::ROW_W'(1);
    end else begin
      row_d = row_q;
    end
    tick.wrap = wrap;
    tick.row  = row_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_q <= RAMP_TOP;
      row_q  <= cps_pkg::ROW_LAST;
    end else if (tick_acc) begin
      ramp_q <= ramp_d;
      row_q  <= row_d;
    end
  end

  cps_level_mem u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .rd_en_i     (tick_acc && wrap),
    .rd_row_i    (row_d),
    .rd_levels_o (rd_levels)
  );

  cps_column_stage #(
    .RAMP_W (RAMP_W)
  ) u_col (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tick_valid_i    (s_axis_tvalid && (mode == cps_pkg::MODE_TICK)),
    .tick_ready_o    (s_axis_tready),
    .tick_i          (tick),
    .ramp_i          (ramp_d),
    .rd_levels_i     (rd_levels),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .pin_direction_o (pin_direction),
    .pin_level_o     (pin_level)
  );

  assign m_axis_tdata = {6'b0, pin_level, pin_direction};

endmodule

// ===== design/cps_checker.sv =====
// Port-level checks of the charlieplexed PWM scanner, bound to its top level.
// Depends on charlieplex_pwm_scanner only through its ports.
module cps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or vanished");

  // Drive at most one line high
  a_one_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[9:5]))
    else $error("more than one line driven high");

  // Drive high only lines that are driven
  a_high_driven: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[9:5] & ~m_axis_tdata[4:0]) == 5'b0))
    else $error("line high while not driven");

  // Drive a row line exactly when some column is lit
  a_row_with_cols: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[4:0] != 5'b0) == (m_axis_tdata[9:5] != 5'b0))
    && ((m_axis_tdata[4:0] == 5'b0) || ($countones(m_axis_tdata[4:0]) >= 2)))
    else $error("row line and columns disagree");

endmodule

bind charlieplex_pwm_scanner cps_checker u_cps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for charlieplex_pwm_scanner: brightness writes and PWM ticks
// over the stream ports, each tick's line drive predicted and compared.
// Depends on cps_pkg and the scanner RTL.
module tb;

  localparam int unsigned RAMP_TOP  = 31;  // LEVELS - 1 of the instance below
  localparam int unsigned N_RANDOM  = 400;
  localparam int unsigned HOLD_LEN  = 90;
  localparam int unsigned MAX_SHOWN = 10;

  typedef struct packed {
    logic                        mode;
    logic [cps_pkg::IDX_W-1:0]   idx;
    logic [cps_pkg::LEVEL_W-1:0] level;
  } scan_item_t;

  typedef struct packed {
    logic [cps_pkg::LINES-1:0] pin_lvl;
    logic [cps_pkg::LINES-1:0] pin_dir;
  } pin_state_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [15:0] s_data = '0;
  logic        s_mode = cps_pkg::MODE_TICK;
  logic        m_ready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [15:0] m_axis_tdata;

  // Stimulus and expected line drive
  scan_item_t  pending_q[$];
  pin_state_t  pin_due_q[$];

  // Predictor state
  logic [4:0]                  ramp_pos = 5'(RAMP_TOP);
  logic [cps_pkg::ROW_W-1:0]   row_sel = cps_pkg::ROW_LAST;
  logic [cps_pkg::LEVEL_W-1:0] led_level_mem [cps_pkg::LEDS];
  logic [cps_pkg::LEVEL_W-1:0] row_lv [cps_pkg::COLS];
  logic [cps_pkg::COLS-1:0]    col_mask = '0;

  // Run statistics
  int unsigned tick_count = 0;
  int unsigned write_count = 0;
  int unsigned wrap_count = 0;
  int unsigned checked_count = 0;
  int unsigned err_count = 0;

  // Sender and receiver pacing
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  int unsigned pattern_cyc = 0;
  int unsigned pattern_sel = 0;

  charlieplex_pwm_scanner #(
    .LEVELS (RAMP_TOP + 1)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_mode),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Common line of each row; lines 3 and 4 trade places
  function automatic logic [cps_pkg::LINES-1:0] common_line(
    input logic [cps_pkg::ROW_W-1:0] row
  );
    logic [cps_pkg::LINES-1:0] line;
    case (row)
      3'd0:    line = 5'b00001;
      3'd1:    line = 5'b00010;
      3'd2:    line = 5'b00100;
      3'd3:    line = 5'b10000;
      default: line = 5'b01000;
    endcase
    return line;
  endfunction

  // Advance the ramp by one tick and work out the line drive it gives
  task automatic predict_tick(output pin_state_t pins);
    logic [cps_pkg::COLS-1:0]  below;
    logic [cps_pkg::LINES-1:0] lines;
    logic [cps_pkg::LINES-1:0] cols;
    logic [cps_pkg::LINES-1:0] row_bit;
    if (ramp_pos == 5'(RAMP_TOP)) begin
      ramp_pos = '0;
      row_sel  = (row_sel == cps_pkg::ROW_LAST) ? cps_pkg::ROW_FIRST : row_sel + 1'b1;
      for (int c = 0; c < cps_pkg::COLS; c++) begin
        row_lv[c] = led_level_mem[int'(row_sel) * cps_pkg::COLS + c];
      end
      col_mask = cps_pkg::COL_ALL;
      wrap_count++;
    end else begin
      ramp_pos = ramp_pos + 1'b1;
    end
    for (int c = 0; c < cps_pkg::COLS; c++) begin
      if ({1'b0, ramp_pos} == row_lv[c]) col_mask[c] = 1'b0;
    end
    below   = cps_pkg::COLS'((1 << row_sel) - 1);
    lines   = {1'b0, col_mask & below} | ({1'b0, col_mask & ~below} << 1);
    cols    = {lines[3], lines[4], lines[2:0]};
    row_bit = common_line(row_sel);
    pins.pin_dir = (cols != '0) ? (cols | row_bit) : '0;
    pins.pin_lvl = (cols != '0) ? row_bit : '0;
  endtask

  task automatic queue_item(input logic mode, input int unsigned idx, input int unsigned lvl);
    scan_item_t item;
    item.mode  = mode;
    item.idx   = cps_pkg::IDX_W'(idx);
    item.level = cps_pkg::LEVEL_W'(lvl);
    pending_q.push_back(item);
  endtask

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    scan_item_t item;
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= '0;
      s_mode  <= cps_pkg::MODE_TICK;
    end else if (!s_valid || s_axis_tready) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        s_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        item = pending_q.pop_front();
        s_valid <= 1'b1;
        s_data  <= {5'b0, item.level, item.idx};
        s_mode  <= item.mode;
        burst_left = burst_left - 1;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Long hold-off on the result side, twice during the run
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && tick_count >= (holds_done + 1) * 110) begin
      hold_left  <= HOLD_LEN;
      holds_done <= holds_done + 1;
    end
  end

  // Receiver: switch among four stall patterns at random
  always @(posedge clk_i) begin
    pattern_cyc = pattern_cyc + 1;
    if (pattern_cyc % 64 == 0) pattern_sel = $urandom_range(0, 3);
    if (!rst_ni || hold_left != 0) begin
      m_ready <= 1'b0;
    end else begin
      case (pattern_sel)
        0:       m_ready <= 1'b1;
        1:       m_ready <= ($urandom_range(0, 1) == 0);
        2:       m_ready <= ($urandom_range(0, 3) == 0);
        default: m_ready <= (pattern_cyc % 5 != 0);
      endcase
    end
  end

  // Monitor: predict on each input transaction, check each result transaction
  always @(posedge clk_i) begin
    pin_state_t pins;
    pin_state_t due;
    if (rst_ni) begin
      if (s_valid && s_axis_tready) begin
        if (s_mode == cps_pkg::MODE_WRITE) begin
          if (s_data[4:0] < cps_pkg::LED_LIMIT) led_level_mem[s_data[4:0]] = s_data[10:5];
          write_count++;
        end else begin
          predict_tick(pins);
          pin_due_q.push_back(pins);
          tick_count++;
        end
      end
      if (m_axis_tvalid && m_ready) begin
        checked_count++;
        if (pin_due_q.size() == 0) begin
          err_count++;
          if (err_count <= MAX_SHOWN)
            $display("%0t: result with nothing pending: dir=%b lvl=%b", $realtime,
                     m_axis_tdata[4:0], m_axis_tdata[9:5]);
        end else begin
          due = pin_due_q.pop_front();
          if (m_axis_tdata[4:0] !== due.pin_dir || m_axis_tdata[9:5] !== due.pin_lvl) begin
            err_count++;
            if (err_count <= MAX_SHOWN)
              $display("%0t: result %0d: dir exp %b got %b, lvl exp %b got %b", $realtime,
                       checked_count, due.pin_dir, m_axis_tdata[4:0],
                       due.pin_lvl, m_axis_tdata[9:5]);
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    #(300000 * 12);
    $display("tb NOT OK");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    int unsigned counted;
    int unsigned idx;
    int unsigned lvl;
    int unsigned drain;
    for (int i = 0; i < cps_pkg::LEDS; i++) led_level_mem[i] = '0;
    for (int c = 0; c < cps_pkg::COLS; c++) row_lv[c] = '0;

    // Directed: extremes of index and level, ignored writes, oversize levels
    queue_item(cps_pkg::MODE_WRITE, 0, 0);
    queue_item(cps_pkg::MODE_WRITE, 1, 63);
    queue_item(cps_pkg::MODE_WRITE, 2, 32);
    queue_item(cps_pkg::MODE_WRITE, 3, 1);
    queue_item(cps_pkg::MODE_WRITE, 19, 32);
    queue_item(cps_pkg::MODE_WRITE, 18, 31);
    queue_item(cps_pkg::MODE_WRITE, 20, 5);
    queue_item(cps_pkg::MODE_WRITE, 31, 63);
    queue_item(cps_pkg::MODE_WRITE, 4, 40);
    queue_item(cps_pkg::MODE_WRITE, 5, 33);
    queue_item(cps_pkg::MODE_WRITE, 6, 16);
    queue_item(cps_pkg::MODE_WRITE, 7, 0);
    queue_item(cps_pkg::MODE_TICK, 0, 0);
    queue_item(cps_pkg::MODE_TICK, 31, 63);
    queue_item(cps_pkg::MODE_TICK, 21, 42);
    for (int i = 0; i < 8; i++) queue_item(cps_pkg::MODE_TICK, i, 0);

    // Random: mostly ticks so that whole rows and scans go by
    counted = 0;
    while (counted < N_RANDOM) begin
      if ($urandom_range(0, 99) < 80) begin
        queue_item(cps_pkg::MODE_TICK, $urandom_range(0, 31), $urandom_range(0, 63));
        counted++;
      end else begin
        idx = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 31) : $urandom_range(0, 19);
        lvl = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 63) : $urandom_range(0, 32);
        queue_item(cps_pkg::MODE_WRITE, idx, lvl);
        if (idx < cps_pkg::LEDS) counted++;
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || s_valid) @(posedge clk_i);
    drain = 0;
    while (pin_due_q.size() != 0 && drain < 5000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (10) @(posedge clk_i);
    if (pin_due_q.size() != 0) begin
      $display("%0d results never arrived", pin_due_q.size());
      err_count++;
    end

    $display("Run covered %0d ticks, %0d brightness writes, %0d row changes, %0d results checked",
             tick_count, write_count, wrap_count, checked_count);
    $display("Result side held off %0d times, %0d mismatches", holds_done, err_count);
    if (err_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== charlieplex_pwm_scanner.f =====
design/cps_pkg.sv
design/cps_level_mem.sv
design/cps_column_stage.sv
design/charlieplex_pwm_scanner.sv
design/cps_checker.sv
sim/tb.sv
